// ===== hw/rtl/ttlc_pkg.sv =====
// Shared types, codes and defaults of the triangle trim-loop classifier.
package ttlc_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned CoordBits = 16;
  localparam int SideAll = 3;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_OUTSIDE  = 2'd0,
    REG_STRADDLE = 2'd1,
    REG_INSIDE   = 2'd2,
    REG_UNUSED   = 2'd3
  } region_e;

  typedef struct packed {
    logic       load_tri;
    logic       ld_mul;
    logic       ld_sum;
    logic       mem_wr;
    logic       mem_rd;
    logic       take_cur;
    logic       take_first;
    logic       take_nxt;
    logic       issue;
    logic [1:0] edge_sel;
    logic       clr_acc;
  } cmd_t;

  typedef struct packed {
    logic       cur_mark;
    logic       busy;
    logic       straddle;
    logic [2:0] parity;
  } sts_t;

endpackage

// ===== hw/rtl/triangle_trim_loop_classifier_top.sv =====
// Top level of the triangle trim-loop classifier.
//
//   bus     dir  beat contents
//   s_axis  in   tuser operation; tlast closes_loop; tdata point and triangle coordinates
//   m_axis  out  tdata region_class, status
//
// Clear and append post their beat on the cycle after they are taken. A classify runs setup,
// then walks each loop segment (one point memory read, then the three triangle edges through
// the shared four-stage crossing pipeline), drains the pipeline and posts the beat; an empty
// table skips the walk and the drain. Reset empties the table at once. A result that waits on
// m_axis holds s_axis_tready low.
module triangle_trim_loop_classifier_top #(
  parameter int unsigned MAX_POINTS = ttlc_pkg::MaxPoints,
  parameter int unsigned COORD_BITS = ttlc_pkg::CoordBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // point_x, point_y, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  // operation
  input  logic [1:0]              s_axis_tuser,
  input  logic                    s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // region_class [1:0], status [2], zero fill
  output logic [7:0]              m_axis_tdata
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  ttlc_pkg::cmd_t cmd;
  ttlc_pkg::sts_t sts;
  logic [AW-1:0]  addr;

  ttlc_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .s_tuser_i (s_axis_tuser),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_o (m_axis_tdata),
    .cmd_o     (cmd),
    .addr_o    (addr),
    .sts_i     (sts)
  );

  ttlc_dp #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .addr_i (addr),
    .tdata_i(s_axis_tdata),
    .tlast_i(s_axis_tlast),
    .sts_o  (sts)
  );

endmodule

// ===== hw/rtl/ttlc_dp.sv =====
// Datapath: point memory, edge equations and the four-stage crossing pipeline.
module ttlc_dp #(
  parameter int unsigned MAX_POINTS = ttlc_pkg::MaxPoints,
  parameter int unsigned COORD_BITS = ttlc_pkg::CoordBits,
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ttlc_pkg::cmd_t          cmd_i,
  input  logic [AW-1:0]           addr_i,
  input  logic [8*COORD_BITS-1:0] tdata_i,
  input  logic                    tlast_i,
  output ttlc_pkg::sts_t          sts_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned LW  = C + 1;
  localparam int unsigned MW  = 2 * C + 1;
  localparam int unsigned LDW = 2 * C + 2;
  localparam int unsigned DW  = 2 * C + 3;
  localparam int unsigned PW  = 3 * C + 4;
  localparam int unsigned EW  = PW + 1;

  logic signed [C-1:0]   vx_q [3];
  logic signed [C-1:0]   vy_q [3];
  logic signed [LW-1:0]  la [3];
  logic signed [LW-1:0]  lb [3];
  logic                  ndx [3];
  logic signed [C-1:0]   ca_a [3];
  logic signed [C-1:0]   cb_a [3];
  logic signed [MW-1:0]  pa_q [3];
  logic signed [MW-1:0]  pb_q [3];
  logic signed [LDW-1:0] ld_q [3];

  logic [2*C:0]          mem [MAX_POINTS];
  logic [2*C:0]          mem_q;
  logic signed [C-1:0]   cx_q, cy_q, fx_q, fy_q, nx_q, ny_q;
  logic                  cm_q;

  for (genvar i = 0; i < 3; i++) begin : g_edge
    localparam int K = (i + 1) % 3;
    logic signed [LW-1:0] aa, ab;
    assign la[i]   = LW'(vy_q[i]) - LW'(vy_q[K]);
    assign lb[i]   = LW'(vx_q[K]) - LW'(vx_q[i]);
    assign aa      = la[i][LW-1] ? -la[i] : la[i];
    assign ab      = lb[i][LW-1] ? -lb[i] : lb[i];
    assign ndx[i]  = $unsigned(aa) > $unsigned(ab);
    assign ca_a[i] = ndx[i] ? vy_q[i] : vx_q[i];
    assign cb_a[i] = ndx[i] ? vy_q[K] : vx_q[K];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.load_tri) begin
        vx_q[i] <= $signed(tdata_i[(2 + 2 * i) * C +: C]);
        vy_q[i] <= $signed(tdata_i[(3 + 2 * i) * C +: C]);
      end
      if (cmd_i.ld_mul) begin
        pa_q[i] <= MW'(la[i]) * MW'(vx_q[i]);
        pb_q[i] <= MW'(lb[i]) * MW'(vy_q[i]);
      end
      if (cmd_i.ld_sum) begin
        ld_q[i] <= LDW'(pa_q[i]) + LDW'(pb_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr_i] <= {tlast_i, tdata_i[2*C-1:0]};
    end
    if (cmd_i.mem_rd) begin
      mem_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_cur) begin
      cx_q <= $signed(mem_q[C-1:0]);
      cy_q <= $signed(mem_q[2*C-1:C]);
      cm_q <= mem_q[2*C];
    end
    if (cmd_i.take_first) begin
      fx_q <= $signed(mem_q[C-1:0]);
      fy_q <= $signed(mem_q[2*C-1:C]);
    end
    if (cmd_i.take_nxt) begin
      nx_q <= cm_q ? fx_q : $signed(mem_q[C-1:0]);
      ny_q <= cm_q ? fy_q : $signed(mem_q[2*C-1:C]);
    end
  end

  // Stage 1: products of the edge line equation
  logic                  v1_q, v2_q, v3_q;
  logic signed [MW-1:0]  m0a_q, m0b_q, m1a_q, m1b_q;
  logic signed [C-1:0]   p0n_q, p1n_q, ca_q, cb_q;
  logic signed [LDW-1:0] lde_q;
  logic [1:0]            e1_q, e2_q, e3_q;
  logic signed [LW-1:0]  la_e, lb_e;

  assign la_e = la[cmd_i.edge_sel];
  assign lb_e = lb[cmd_i.edge_sel];

  always_ff @(posedge clk_i) begin
    m0a_q <= MW'(cx_q) * MW'(la_e);
    m0b_q <= MW'(cy_q) * MW'(lb_e);
    m1a_q <= MW'(nx_q) * MW'(la_e);
    m1b_q <= MW'(ny_q) * MW'(lb_e);
    p0n_q <= ndx[cmd_i.edge_sel] ? cy_q : cx_q;
    p1n_q <= ndx[cmd_i.edge_sel] ? ny_q : nx_q;
    ca_q  <= ca_a[cmd_i.edge_sel];
    cb_q  <= cb_a[cmd_i.edge_sel];
    lde_q <= ld_q[cmd_i.edge_sel];
    e1_q  <= cmd_i.edge_sel;
  end

  // Stage 2: signed distances and offsets along the dominant axis
  logic signed [DW-1:0] d0_q, d1_q;
  logic signed [LW-1:0] ua_q, va_q, ub_q, vb_q;

  always_ff @(posedge clk_i) begin
    d0_q <= DW'(m0a_q) + DW'(m0b_q) - DW'(lde_q);
    d1_q <= DW'(m1a_q) + DW'(m1b_q) - DW'(lde_q);
    ua_q <= LW'(p1n_q) - LW'(ca_q);
    va_q <= LW'(p0n_q) - LW'(ca_q);
    ub_q <= LW'(p1n_q) - LW'(cb_q);
    vb_q <= LW'(p0n_q) - LW'(cb_q);
    e2_q <= e1_q;
  end

  // Stage 3: cross-multiplied crossing position
  logic signed [PW-1:0] pa0_q, qa_q, pb0_q, qb_q;
  logic                 s0_q, cross_q, dpos_q;

  always_ff @(posedge clk_i) begin
    pa0_q   <= PW'(ua_q) * PW'(d0_q);
    qa_q    <= PW'(va_q) * PW'(d1_q);
    pb0_q   <= PW'(ub_q) * PW'(d0_q);
    qb_q    <= PW'(vb_q) * PW'(d1_q);
    s0_q    <= d0_q[DW-1];
    cross_q <= d0_q[DW-1] != d1_q[DW-1];
    dpos_q  <= d0_q > d1_q;
    e3_q    <= e2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 4: classify the crossing and accumulate
  logic signed [EW-1:0] da, db;
  logic                 ba, bb;
  logic [1:0]           neg_q, neg_n;
  logic [2:0]           par_q;
  logic                 strad_q;

  assign da    = EW'(pa0_q) - EW'(qa_q);
  assign db    = EW'(pb0_q) - EW'(qb_q);
  assign ba    = dpos_q ? da[EW-1] : (!da[EW-1] && (da != '0));
  assign bb    = dpos_q ? db[EW-1] : (!db[EW-1] && (db != '0));
  assign neg_n = neg_q + {1'b0, s0_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q   <= '0;
      par_q   <= '0;
      strad_q <= 1'b0;
    end else if (cmd_i.clr_acc) begin
      neg_q   <= '0;
      par_q   <= '0;
      strad_q <= 1'b0;
    end else if (v3_q) begin
      if (cross_q) begin
        if (ba && bb) begin
          par_q[e3_q] <= ~par_q[e3_q];
        end else if (ba || bb) begin
          strad_q <= 1'b1;
        end
      end
      if (e3_q == 2'd2) begin
        neg_q <= '0;
        if (neg_n == 2'(ttlc_pkg::SideAll) || neg_n == 2'd0) begin
          strad_q <= 1'b1;
        end
      end else begin
        neg_q <= neg_n;
      end
    end
  end

  assign sts_o.cur_mark = cm_q;
  assign sts_o.busy     = v1_q | v2_q | v3_q;
  assign sts_o.straddle = strad_q;
  assign sts_o.parity   = par_q;

endmodule

// ===== hw/rtl/ttlc_ctrl.sv =====
// Controller: handshakes, point count, segment walk sequencer and result register.
module ttlc_ctrl #(
  parameter int unsigned MAX_POINTS = ttlc_pkg::MaxPoints,
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  logic [1:0]     s_tuser_i,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic [7:0]     m_tdata_o,
  output ttlc_pkg::cmd_t cmd_o,
  output logic [AW-1:0]  addr_o,
  input  ttlc_pkg::sts_t sts_i
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SETUP0 = 10'b0000000010,
    ST_SETUP1 = 10'b0000000100,
    ST_FIRST  = 10'b0000001000,
    ST_NEXT   = 10'b0000010000,
    ST_LOAD   = 10'b0000100000,
    ST_EDGE   = 10'b0001000000,
    ST_DRAIN  = 10'b0010000000,
    ST_DONE   = 10'b0100000000,
    ST_SPARE  = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d, j_q, j_d, jp1;
  logic [1:0]        e_q, e_d;
  logic              ov_q, ov_d;
  logic [1:0]        reg_q, reg_d;
  logic              stat_q, stat_d;
  logic              can_out, acc, last_seg;
  ttlc_pkg::op_e     op;
  ttlc_pkg::region_e region;

  assign op       = ttlc_pkg::op_e'(s_tuser_i);
  assign can_out  = !ov_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE) && can_out;
  assign acc      = s_tvalid_i && s_tready_o;
  assign jp1      = j_q + CW'(1);
  assign last_seg = jp1 >= count_q;

  always_comb begin
    priority if (sts_i.straddle) begin
      region = ttlc_pkg::REG_STRADDLE;
    end else if (&sts_i.parity) begin
      region = ttlc_pkg::REG_INSIDE;
    end else if (~|sts_i.parity) begin
      region = ttlc_pkg::REG_OUTSIDE;
    end else begin
      region = ttlc_pkg::REG_STRADDLE;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    j_d     = j_q;
    e_d     = e_q;
    ov_d    = ov_q && !m_tready_i;
    reg_d   = reg_q;
    stat_d  = stat_q;
    cmd_o   = '0;
    addr_o  = count_q[AW-1:0];
    cmd_o.edge_sel = e_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (op)
            ttlc_pkg::OP_CLEAR: begin
              count_d = '0;
              ov_d = 1'b1; reg_d = ttlc_pkg::REG_OUTSIDE; stat_d = 1'b0;
            end
            ttlc_pkg::OP_APPEND: begin
              ov_d = 1'b1; reg_d = ttlc_pkg::REG_OUTSIDE;
              if (count_q == CW'(MAX_POINTS)) begin
                stat_d = 1'b1;
              end else begin
                stat_d = 1'b0;
                cmd_o.mem_wr = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            ttlc_pkg::OP_CLASSIFY: begin
              cmd_o.load_tri = 1'b1;
              cmd_o.clr_acc  = 1'b1;
              state_d = ST_SETUP0;
            end
            default: begin
              ov_d = 1'b1; reg_d = ttlc_pkg::REG_OUTSIDE; stat_d = 1'b0;
            end
          endcase
        end
      end
      ST_SETUP0: begin
        cmd_o.ld_mul = 1'b1;
        state_d = ST_SETUP1;
      end
      ST_SETUP1: begin
        cmd_o.ld_sum = 1'b1;
        addr_o = '0;
        if (count_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd_o.take_cur   = 1'b1;
        cmd_o.take_first = 1'b1;
        j_d = '0;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        addr_o = jp1[AW-1:0];
        if (!sts_i.cur_mark && last_seg) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.take_nxt = 1'b1;
        e_d = '0;
        state_d = ST_EDGE;
      end
      ST_EDGE: begin
        cmd_o.issue = 1'b1;
        if (e_q == 2'd2) begin
          if (sts_i.cur_mark && last_seg) begin
            state_d = ST_DRAIN;
          end else begin
            cmd_o.take_cur   = 1'b1;
            cmd_o.take_first = sts_i.cur_mark;
            j_d = jp1;
            state_d = ST_NEXT;
          end
        end else begin
          e_d = e_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_out) begin
          ov_d = 1'b1; reg_d = region; stat_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      j_q     <= '0;
      e_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      j_q     <= j_d;
      e_q     <= e_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reg_q  <= reg_d;
    stat_q <= stat_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {5'd0, stat_q, reg_q};

endmodule

// ===== hw/rtl/ttlc_chk.sv =====
// Port checker for the triangle trim-loop classifier, bound to the top level.
module ttlc_chk #(
  parameter int unsigned COORD_BITS = ttlc_pkg::CoordBits
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic [8*COORD_BITS-1:0] s_axis_tdata,
  input logic [1:0]              s_axis_tuser,
  input logic                    s_axis_tlast,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [7:0]              m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken while result register blocked");

  a_quick_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != ttlc_pkg::OP_CLASSIFY
      |=> m_axis_tvalid)
    else $error("clear or append gave no result beat");

  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != ttlc_pkg::REG_UNUSED &&
      !(m_axis_tdata[2] && m_axis_tdata[1:0] != ttlc_pkg::REG_OUTSIDE) &&
      m_axis_tdata[7:3] == 5'd0)
    else $error("malformed result beat");

endmodule

bind triangle_trim_loop_classifier_top ttlc_chk #(
  .COORD_BITS(COORD_BITS)
) u_ttlc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
